### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the mixer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// implication with the consequence checked in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

### hdl/mvpm_pkg.sv
// ----------------------------------------------------------------------------
// mvpm_pkg
// types and codes shared by the multi-voice pcm mixer
// ----------------------------------------------------------------------------
package mvpm_pkg;

    typedef enum logic [2:0] {
        KIND_WRITE  = 3'd0,
        KIND_DEFINE = 3'd1,
        KIND_PLAY   = 3'd2,
        KIND_STOP   = 3'd3,
        KIND_MUTE   = 3'd4,
        KIND_MIX    = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTREADY = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOVOICE  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_MUL,
        S_ACC,
        S_OUT
    } state_t;

    // clip table depth and sample memory depth follow the 4-bit clip
    // field and the 16-bit address field
    localparam int CLIPS        = 16;
    localparam int SAMPLE_WORDS = 65536;

    localparam logic signed [20:0] SAT_MAX = 21'sd32767;
    localparam logic signed [20:0] SAT_MIN = -21'sd32768;

endpackage

### hdl/multi_voice_pcm_mixer_top.sv
// ----------------------------------------------------------------------------
// multi_voice_pcm_mixer_top
// sample memory, clip table and voices mixed by one shared multiply unit
// ----------------------------------------------------------------------------
//  channel | handshake                     | payload
//  in      | in_valid / in_ready           | kind clip address sample_in length gain frames
//  out     | out_valid / out_ready         | status muted_now mixed_sample last
//  cfg     | cfg_valid / cfg_ready         | cfg_data (enabled)
//
//  non-mix requests go to the result directly, a play that can start a voice
//  after a scan of the voices one a cycle. a mix frame walks every voice in
//  turn: an active voice is scanned, read through the single memory read port,
//  multiplied and accumulated, an idle voice is only scanned, and the frame
//  ends with its result. reset clears control, clip table and voice state at
//  once; the sample memory is never cleared.
//  a stalled result holds the sequencer; in_ready is high only when idle.
module multi_voice_pcm_mixer_top
    import mvpm_pkg::*;
#(
    parameter int VOICES       = 12,
    parameter int MAX_FRAMES   = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         kind,
    input  logic [3:0]         clip,
    input  logic [15:0]        address,
    input  logic signed [15:0] sample_in,
    input  logic [15:0]        length,
    input  logic [9:0]         gain,
    input  logic [6:0]         frames,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic               muted_now,
    output logic signed [15:0] mixed_sample,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);

`include "assert_macros.svh"

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = (CLIPS > 1) ? $clog2(CLIPS) : 1;
    localparam int AW = $clog2(SAMPLE_WORDS);
    localparam int FW = $clog2(MAX_FRAMES + 1);
    // each voice term fits 18 signed bits; room for all voices on top
    localparam int SW = 18 + VW;

    // sample memory, one write or one read per cycle
    logic [15:0] mem [SAMPLE_WORDS];
    logic [15:0] rd_data_reg;

    // clip table and voice state
    logic [15:0] clip_start_reg [CLIPS];
    logic [15:0] clip_length_reg [CLIPS];
    logic [9:0]  clip_gain_reg [CLIPS];
    logic [VOICES-1:0] active_reg;
    logic [15:0] v_start_reg [VOICES];
    logic [15:0] v_len_reg [VOICES];
    logic [9:0]  v_gain_reg [VOICES];
    logic [15:0] v_pos_reg [VOICES];

    logic enabled_reg, muted_reg;
    state_t state_reg, state_next;
    logic [VW-1:0] vidx_reg;
    logic [FW-1:0] frames_reg, fcnt_reg;
    logic          is_mix_reg, is_play_reg;
    logic [CW-1:0] pclip_reg;
    logic signed [SW-1:0] sum_reg;
    logic signed [26:0] prod_reg;
    logic [1:0]  ostatus_reg;
    logic signed [15:0] omix_reg;
    logic        olast_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);

    logic accept;
    assign accept = in_valid && in_ready;

    logic [FW-1:0] frames_sat;
    always_comb
    begin
        if ({1'b0, frames} > 8'(MAX_FRAMES))
            frames_sat = FW'(MAX_FRAMES);
        else
            frames_sat = FW'(frames);
    end

    logic clip_ok;
    assign clip_ok = ({4'b0, clip} < 8'(CLIPS));

    logic last_voice;
    assign last_voice = (vidx_reg == VW'(VOICES - 1));

    // per-voice end check and address for the voice under the sequencer
    logic v_done;
    logic [15:0] v_addr;
    assign v_done = (v_pos_reg[vidx_reg] >= v_len_reg[vidx_reg]);
    assign v_addr = v_start_reg[vidx_reg] + v_pos_reg[vidx_reg];

    // saturated frame sum
    logic signed [15:0] sat_sum;
    always_comb
    begin
        if (sum_reg > SAT_MAX)
            sat_sum = 16'sh7fff;
        else if (sum_reg < SAT_MIN)
            sat_sum = -16'sh8000;
        else
            sat_sum = sum_reg[15:0];
    end

    // truncate toward zero: bias negatives before the shift
    logic signed [26:0] prod_adj;
    assign prod_adj = prod_reg + (prod_reg[26] ? 27'sd255 : 27'sd0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_MIX)
                        state_next = (enabled_reg && frames != 7'd0) ? S_SCAN : S_IDLE;
                    else if (kind == KIND_PLAY && enabled_reg && !muted_reg && clip_ok
                             && clip_length_reg[clip[CW-1:0]] != 16'd0)
                        state_next = S_SCAN;
                    else
                        state_next = S_OUT;
                end
            end
            S_SCAN:
            begin
                if (is_play_reg)
                begin
                    if (!active_reg[vidx_reg] || last_voice)
                        state_next = S_OUT;
                end
                else if (active_reg[vidx_reg] && !v_done)
                    state_next = S_READ;
                else if (last_voice)
                    state_next = S_OUT;
            end
            S_READ:  state_next = S_MUL;
            S_MUL:   state_next = S_ACC;
            S_ACC:   state_next = last_voice ? S_OUT : S_SCAN;
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (is_mix_reg && !olast_reg)
                        state_next = S_SCAN;
                    else
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        out_valid    = (state_reg == S_OUT);
        status       = ostatus_reg;
        muted_now    = muted_reg;
        mixed_sample = omix_reg;
        last         = olast_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // memory port
    always_ff @(posedge clk)
    begin
        if (accept && kind == KIND_WRITE)
            mem[address[AW-1:0]] <= sample_in;
        if (state_reg == S_READ)
            rd_data_reg <= mem[v_addr[AW-1:0]];
    end

    // shared multiplier, registered
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
            prod_reg <= $signed(rd_data_reg) * $signed({1'b0, v_gain_reg[vidx_reg]});
    end

    // control and tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            muted_reg   <= 1'b0;
            active_reg  <= '0;
            vidx_reg    <= '0;
            frames_reg  <= '0;
            fcnt_reg    <= '0;
            is_mix_reg  <= 1'b0;
            is_play_reg <= 1'b0;
            pclip_reg   <= '0;
            sum_reg     <= '0;
            ostatus_reg <= ST_OK;
            omix_reg    <= '0;
            olast_reg   <= 1'b0;
            for (int c = 0; c < CLIPS; c++)
            begin
                clip_start_reg[c]  <= '0;
                clip_length_reg[c] <= '0;
                clip_gain_reg[c]   <= '0;
            end
            for (int v = 0; v < VOICES; v++)
            begin
                v_start_reg[v] <= '0;
                v_len_reg[v]   <= '0;
                v_gain_reg[v]  <= '0;
                v_pos_reg[v]   <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                enabled_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        vidx_reg    <= '0;
                        sum_reg     <= '0;
                        fcnt_reg    <= '0;
                        frames_reg  <= frames_sat;
                        is_mix_reg  <= (kind == KIND_MIX);
                        is_play_reg <= (kind == KIND_PLAY);
                        pclip_reg   <= clip[CW-1:0];
                        omix_reg    <= '0;
                        olast_reg   <= 1'b1;
                        ostatus_reg <= ST_OK;
                        case (kind)
                            KIND_DEFINE:
                            begin
                                if (clip_ok)
                                begin
                                    clip_start_reg[clip[CW-1:0]]  <= address;
                                    clip_length_reg[clip[CW-1:0]] <= length;
                                    clip_gain_reg[clip[CW-1:0]]   <= gain;
                                end
                            end
                            KIND_PLAY:
                            begin
                                if (!enabled_reg)
                                    ostatus_reg <= ST_NOTREADY;
                                else if (muted_reg)
                                    ostatus_reg <= ST_OK;
                                else if (!clip_ok || clip_length_reg[clip[CW-1:0]] == 16'd0)
                                    ostatus_reg <= ST_EMPTY;
                            end
                            KIND_STOP:
                            begin
                                if (enabled_reg)
                                    active_reg <= '0;
                                else
                                    ostatus_reg <= ST_NOTREADY;
                            end
                            KIND_MUTE:
                            begin
                                muted_reg <= !muted_reg;
                                if (!muted_reg && enabled_reg)
                                    active_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (is_play_reg)
                    begin
                        // lowest free voice
                        if (!active_reg[vidx_reg])
                        begin
                            active_reg[vidx_reg] <= 1'b1;
                            v_start_reg[vidx_reg] <= clip_start_reg[pclip_reg];
                            v_len_reg[vidx_reg]   <= clip_length_reg[pclip_reg];
                            v_gain_reg[vidx_reg]  <= clip_gain_reg[pclip_reg];
                            v_pos_reg[vidx_reg]   <= '0;
                        end
                        else if (last_voice)
                            ostatus_reg <= ST_NOVOICE;
                        else
                            vidx_reg <= vidx_reg + 1'b1;
                    end
                    else if (active_reg[vidx_reg] && !v_done)
                        ;
                    else
                    begin
                        if (active_reg[vidx_reg])
                            active_reg[vidx_reg] <= 1'b0;
                        if (last_voice)
                        begin
                            omix_reg  <= sat_sum;
                            olast_reg <= (fcnt_reg + 1'b1 == frames_reg);
                        end
                        else
                            vidx_reg <= vidx_reg + 1'b1;
                    end
                end
                S_READ:
                    v_pos_reg[vidx_reg] <= v_pos_reg[vidx_reg] + 16'd1;
                S_MUL: ;
                S_ACC:
                begin
                    if (last_voice)
                    begin
                        omix_reg  <= (sum_reg + SW'(prod_adj >>> 8) > SAT_MAX) ? 16'sh7fff :
                                     (sum_reg + SW'(prod_adj >>> 8) < SAT_MIN) ? -16'sh8000 :
                                     16'(sum_reg + SW'(prod_adj >>> 8));
                        olast_reg <= (fcnt_reg + 1'b1 == frames_reg);
                    end
                    else
                    begin
                        sum_reg  <= sum_reg + SW'(prod_adj >>> 8);
                        vidx_reg <= vidx_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (out_ready && is_mix_reg)
                    begin
                        fcnt_reg <= fcnt_reg + 1'b1;
                        vidx_reg <= '0;
                        sum_reg  <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    `ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, !out_valid)
    `ASSERT_IMPL(a_mix_ok, clk, rst_n, out_valid && is_mix_reg, status == ST_OK)
    `ASSERT_IMPL(a_nonmix_zero, clk, rst_n, out_valid && !is_mix_reg,
                 mixed_sample == 16'sd0 && last)
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
                 out_valid && $stable(mixed_sample))

endmodule
